// ===== src/rmft_pkg.sv =====
// ----------------------------------------------------------------------------
// rmft_pkg
// Shared types and constants of the range-match flow table.
// ----------------------------------------------------------------------------
package rmft_pkg;

  localparam int RULE_DEPTH    = 16;
  localparam int PENDING_DEPTH = 16;
  localparam int QUERY_DEPTH   = 16;

  localparam int RIDX_W = $clog2(RULE_DEPTH);
  localparam int RCNT_W = $clog2(RULE_DEPTH + 1);
  localparam int PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int QIDX_W = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUERY_DEPTH + 1);

  localparam logic [9:0] MAX_IP = 10'd1000;

  // rule kinds
  localparam logic [1:0] RK_DROP    = 2'd0;
  localparam logic [1:0] RK_FORWARD = 2'd1;
  localparam logic [1:0] RK_SEND    = 2'd2;

  // result kinds
  localparam logic [2:0] K_FWD     = 3'd0;
  localparam logic [2:0] K_DROP    = 3'd1;
  localparam logic [2:0] K_LEFT    = 3'd2;
  localparam logic [2:0] K_RIGHT   = 3'd3;
  localparam logic [2:0] K_QUERY   = 3'd4;
  localparam logic [2:0] K_SUPPR   = 3'd5;
  localparam logic [2:0] K_DONE    = 3'd6;
  localparam logic [2:0] K_OVF     = 3'd7;

  localparam logic [0:0] CFG_OWN_LOW  = 1'b0;
  localparam logic [0:0] CFG_OWN_HIGH = 1'b1;

  typedef struct packed {
    logic [9:0] sl;
    logic [9:0] sh;
    logic [9:0] dl;
    logic [9:0] dh;
    logic [1:0] kind;
    logic       port;
  } rule_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  src;
    logic [9:0]  dst;
    logic [3:0]  idx;
    logic [15:0] hits;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [0:0] action;
    logic [9:0] src_ip;
    logic [9:0] dst_ip;
    rule_t      rule;
  } item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic             load_item;   // capture accepted item
    logic             set_pkt;     // current packet := item addresses
    logic             set_pend;    // current packet := pending entry read
    logic             rscan_start; // start rule scan at top
    logic             rscan_step;
    logic             dscan_step;  // duplicate scan step
    logic             qscan_step;
    logic             pscan_step;
    logic             rd_pend;     // issue pending read at pscan index
    logic             rd_hits;     // issue hit-count read at rule scan index
    logic             bump;        // write incremented count
    logic             append;      // append rule
    logic             record;      // record query + pending
    logic             keep;        // compact pending entry
    logic             finish_pend; // pending_used := write index
    logic             clr_scan;    // reset scan indices
    logic             res_hit;
    logic [2:0]       res_kind_fixed;
    logic             res_fixed;
    logic             res_last;
    logic             res_zero_addr;
  } cmd_t;

  typedef struct packed {
    logic rule_hit;    // rule at scan index matches
    logic rule_end;    // scan index at 0
    logic dup_hit;
    logic dup_end;
    logic q_hit;
    logic q_end;       // no more queried entries
    logic p_end;       // no more pending entries
    logic rules_full;
    logic store_full;
    logic is_add;
  } stat_t;

endpackage

// ===== src/rmft_if.sv =====
// ----------------------------------------------------------------------------
// rmft_stream_if
// Valid/ready channels of the flow table.
// ----------------------------------------------------------------------------
interface rmft_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rmft_dp.sv =====
// ----------------------------------------------------------------------------
// rmft_dp
// Datapath: rule table, hit counters, pending and queried stores, result reg.
// ----------------------------------------------------------------------------
module rmft_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rmft_pkg::item_t      item,
  input  logic                 cfg_we,
  input  logic                 cfg_idx,
  input  logic [9:0]           cfg_val,
  input  rmft_pkg::cmd_t       cmd,
  output rmft_pkg::stat_t      stat,
  output rmft_pkg::result_t    res
);

  rmft_pkg::rule_t rules [1:rmft_pkg::RULE_DEPTH-1];
  logic [15:0]     hits  [rmft_pkg::RULE_DEPTH];
  logic [19:0]     pend  [rmft_pkg::PENDING_DEPTH];
  logic [19:0]     qry   [rmft_pkg::QUERY_DEPTH];

  logic [9:0] own_lo_r, own_hi_r;
  rmft_pkg::item_t item_r;
  logic [rmft_pkg::RCNT_W-1:0] rused_r;
  logic [rmft_pkg::PCNT_W-1:0] pused_r, pidx_r, pwr_r;
  logic [rmft_pkg::QCNT_W-1:0] qused_r, qidx_r;
  logic [rmft_pkg::RIDX_W-1:0] ridx_r, didx_r, hidx_r;
  logic                        dup_r;
  logic [9:0]  psrc_r, pdst_r;
  logic [19:0] prd_r;
  logic [15:0] hrd_r;
  rmft_pkg::rule_t rcur, dcur;
  rmft_pkg::result_t res_r;
  logic [rmft_pkg::RIDX_W-1:0] rused_m1;

  assign rused_m1 = rmft_pkg::RIDX_W'(rused_r - 1'b1);

  // rule read with built-in entry 0
  always_comb begin
    rcur = (ridx_r == '0) ? {10'd0, rmft_pkg::MAX_IP, own_lo_r, own_hi_r,
                             rmft_pkg::RK_FORWARD, 1'b0} : rules[ridx_r];
    dcur = (didx_r == '0) ? {10'd0, rmft_pkg::MAX_IP, own_lo_r, own_hi_r,
                             rmft_pkg::RK_FORWARD, 1'b0} : rules[didx_r];
  end

  always_comb begin
    stat.rule_hit  = psrc_r >= rcur.sl && psrc_r <= rcur.sh &&
                     pdst_r >= rcur.dl && pdst_r <= rcur.dh;
    stat.rule_end  = ridx_r == '0;
    stat.dup_hit   = dcur.sl == item_r.rule.sl && dcur.sh == item_r.rule.sh &&
                     dcur.dl == item_r.rule.dl && dcur.dh == item_r.rule.dh &&
                     dcur.kind == item_r.rule.kind;
    stat.dup_end   = didx_r == rused_m1;
    stat.q_hit     = qidx_r < qused_r &&
                     qry[qidx_r[rmft_pkg::QIDX_W-1:0]] == {psrc_r, pdst_r};
    stat.q_end     = qidx_r >= qused_r;
    stat.p_end     = pidx_r >= pused_r;
    stat.rules_full = rused_r >= rmft_pkg::RCNT_W'(rmft_pkg::RULE_DEPTH);
    stat.store_full = qused_r >= rmft_pkg::QCNT_W'(rmft_pkg::QUERY_DEPTH) ||
                      pused_r >= rmft_pkg::PCNT_W'(rmft_pkg::PENDING_DEPTH);
    stat.is_add    = item_r.action[0];
  end

  // synchronous memory reads and writes, item and packet capture
  always_ff @(posedge clk) begin
    if (cmd.rd_pend) prd_r <= pend[pidx_r[rmft_pkg::PIDX_W-1:0]];
    if (cmd.rd_hits) hrd_r <= hits[ridx_r];
    if (cmd.keep)    pend[pwr_r[rmft_pkg::PIDX_W-1:0]] <= {psrc_r, pdst_r};
    if (cmd.record) begin
      pend[pused_r[rmft_pkg::PIDX_W-1:0]] <= {psrc_r, pdst_r};
      qry[qused_r[rmft_pkg::QIDX_W-1:0]]  <= {psrc_r, pdst_r};
    end
    if (cmd.append) rules[rused_r[rmft_pkg::RIDX_W-1:0]] <= item_r.rule;
    if (cmd.load_item) item_r <= item;
    if (cmd.set_pkt) begin
      psrc_r <= item_r.src_ip;
      pdst_r <= item_r.dst_ip;
    end else if (cmd.set_pend) begin
      psrc_r <= prd_r[19:10];
      pdst_r <= prd_r[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_lo_r <= 10'd0;
      own_hi_r <= rmft_pkg::MAX_IP;
      rused_r  <= rmft_pkg::RCNT_W'(1);
      pused_r  <= '0;
      qused_r  <= '0;
      pidx_r   <= '0;
      pwr_r    <= '0;
      qidx_r   <= '0;
      ridx_r   <= '0;
      didx_r   <= '0;
      hidx_r   <= '0;
      for (int i = 0; i < rmft_pkg::RULE_DEPTH; i++) hits[i] <= 16'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == rmft_pkg::CFG_OWN_LOW) own_lo_r <= cfg_val;
        else own_hi_r <= cfg_val;
      end
      if (cmd.clr_scan) begin
        qidx_r <= '0;
        didx_r <= '0;
        pidx_r <= '0;
        pwr_r  <= '0;
      end
      if (cmd.rscan_start) ridx_r <= rused_m1;
      else if (cmd.rscan_step) ridx_r <= ridx_r - 1'b1;
      if (cmd.dscan_step) didx_r <= didx_r + 1'b1;
      if (cmd.qscan_step) qidx_r <= qidx_r + 1'b1;
      if (cmd.pscan_step) pidx_r <= pidx_r + 1'b1;
      if (cmd.keep) pwr_r <= pwr_r + 1'b1;
      if (cmd.finish_pend) pused_r <= pwr_r;
      if (cmd.record) begin
        pused_r <= pused_r + 1'b1;
        qused_r <= qused_r + 1'b1;
      end
      if (cmd.append) begin
        rused_r <= rused_r + 1'b1;
        hits[rused_r[rmft_pkg::RIDX_W-1:0]] <= 16'd0;
      end
      if (cmd.bump && hrd_r != 16'hFFFF) hits[ridx_r] <= hrd_r + 16'd1;
      if (cmd.rd_hits) hidx_r <= ridx_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_hit) begin
      res_r.kind <= (rcur.kind == rmft_pkg::RK_FORWARD) ? rmft_pkg::K_FWD :
                    (rcur.kind == rmft_pkg::RK_SEND) ?
                    (rcur.port ? rmft_pkg::K_RIGHT : rmft_pkg::K_LEFT) :
                    rmft_pkg::K_DROP;
      res_r.src  <= psrc_r;
      res_r.dst  <= pdst_r;
      res_r.idx  <= 4'(hidx_r);
      res_r.hits <= (hrd_r == 16'hFFFF) ? hrd_r : hrd_r + 16'd1;
      res_r.last <= cmd.res_last;
    end else if (cmd.res_fixed) begin
      res_r.kind <= cmd.res_kind_fixed;
      res_r.src  <= cmd.res_zero_addr ? 10'd0 : psrc_r;
      res_r.dst  <= cmd.res_zero_addr ? 10'd0 : pdst_r;
      res_r.idx  <= 4'd0;
      res_r.hits <= 16'd0;
      res_r.last <= cmd.res_last;
    end
  end

  assign res = res_r;

endmodule

// ===== src/rmft_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmft_ctrl
// Sequencer for lookup and add-rule items; owns both handshakes' control.
// ----------------------------------------------------------------------------
module rmft_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  output logic            in_rdy,
  output logic            out_vld,
  input  logic            out_rdy,
  input  rmft_pkg::stat_t stat,
  output rmft_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_RSCAN = 4'd2;  // rule scan for current packet
  localparam logic [3:0] S_HREAD = 4'd3;  // hit count read settles
  localparam logic [3:0] S_HIT   = 4'd4;
  localparam logic [3:0] S_QSCAN = 4'd5;
  localparam logic [3:0] S_DSCAN = 4'd6;
  localparam logic [3:0] S_PRD   = 4'd7;  // pending read
  localparam logic [3:0] S_PLOAD = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;  // result waiting
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       ovf_r, ovf_nxt;
  logic       fin_r, fin_nxt; // item ends after current output

  assign in_rdy  = state_r == S_IDLE;
  assign out_vld = state_r == S_OUT;

  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.load_item = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.clr_scan = 1'b1;
        ovf_nxt = 1'b0;
        if (stat.is_add) state_nxt = S_DSCAN;
        else begin
          cmd.set_pkt = 1'b1;
          cmd.rscan_start = 1'b1;
          state_nxt = S_RSCAN;
        end
      end
      S_DSCAN: begin
        if (stat.dup_hit) begin
          cmd.pscan_step = 1'b0;
          state_nxt = S_PRD;
        end else if (stat.dup_end) begin
          if (stat.rules_full) ovf_nxt = 1'b1;
          else cmd.append = 1'b1;
          state_nxt = S_PRD;
        end else cmd.dscan_step = 1'b1;
      end
      S_PRD: begin
        if (stat.p_end) begin
          cmd.finish_pend = 1'b1;
          cmd.res_fixed = 1'b1;
          cmd.res_zero_addr = 1'b1;
          cmd.res_last = 1'b1;
          cmd.res_kind_fixed = ovf_r ? rmft_pkg::K_OVF : rmft_pkg::K_DONE;
          fin_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.rd_pend = 1'b1;
          state_nxt = S_PLOAD;
        end
      end
      S_PLOAD: begin
        cmd.set_pend = 1'b1;
        cmd.rscan_start = 1'b1;
        state_nxt = S_RSCAN;
      end
      S_RSCAN: begin
        if (stat.rule_hit) begin
          cmd.rd_hits = 1'b1;
          state_nxt = S_HREAD;
        end else if (stat.rule_end) begin
          if (stat.is_add) begin
            cmd.keep = 1'b1;
            cmd.pscan_step = 1'b1;
            state_nxt = S_PRD;
          end else state_nxt = S_QSCAN;
        end else cmd.rscan_step = 1'b1;
      end
      S_HREAD: state_nxt = S_HIT;
      S_HIT: begin
        cmd.bump = 1'b1;
        cmd.res_hit = 1'b1;
        cmd.res_last = !stat.is_add;
        fin_nxt = !stat.is_add;
        if (stat.is_add) cmd.pscan_step = 1'b1;
        state_nxt = S_OUT;
      end
      S_QSCAN: begin
        if (stat.q_hit) begin
          cmd.res_fixed = 1'b1;
          cmd.res_kind_fixed = rmft_pkg::K_SUPPR;
          cmd.res_last = 1'b1;
          fin_nxt = 1'b1;
          state_nxt = S_OUT;
        end else if (stat.q_end) begin
          cmd.res_fixed = 1'b1;
          cmd.res_last = 1'b1;
          fin_nxt = 1'b1;
          if (stat.store_full) cmd.res_kind_fixed = rmft_pkg::K_OVF;
          else begin
            cmd.res_kind_fixed = rmft_pkg::K_QUERY;
            cmd.record = 1'b1;
          end
          state_nxt = S_OUT;
        end else cmd.qscan_step = 1'b1;
      end
      S_OUT: if (out_rdy) state_nxt = fin_r ? S_IDLE : S_PRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovf_r   <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ===== src/range_match_flow_table.sv =====
// ----------------------------------------------------------------------------
// range_match_flow_table
// Range-match flow table of a software-defined switch.
// ----------------------------------------------------------------------------
// One item is processed at a time. A lookup walks the rule table from newest
// to oldest, one rule per cycle, then on a miss the queried pairs one per
// cycle. An add-rule item scans the table for a duplicate (one rule a cycle)
// and then, for each pending packet, does a pending read plus a rule walk plus,
// on a hit, a hit-count read and a result. Results leave through an output
// register; the block takes the next item after the last one.
module range_match_flow_table (
  input  logic clk,
  input  logic rst_n,
  rmft_stream_if.sink   in_ch,
  rmft_stream_if.source out_ch,
  rmft_stream_if.sink   cfg_ch
);

  rmft_pkg::item_t   item;
  rmft_pkg::cmd_t    cmd;
  rmft_pkg::stat_t   stat;
  rmft_pkg::result_t res;
  logic in_rdy, in_fire;

  // in_ch.data: action, src, dst, rsl, rsh, rdl, rdh, kind, port (MSB first)
  assign item = in_ch.data;
  assign in_ch.ready = in_rdy;
  assign in_fire = in_ch.valid && in_rdy;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.data = res;

  rmft_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_rdy,
    .out_vld(out_ch.valid), .out_rdy(out_ch.ready), .stat, .cmd
  );

  rmft_dp u_dp (
    .clk, .rst_n, .item,
    .cfg_we(cfg_ch.valid),
    .cfg_idx(cfg_ch.data[10]),
    .cfg_val(cfg_ch.data[9:0]),
    .cmd, .stat, .res
  );

endmodule

// ===== src/rmft_checker.sv =====
// ----------------------------------------------------------------------------
// rmft_checker
// Port-level checks of the flow table.
// ----------------------------------------------------------------------------
module rmft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [43:0] out_data
);

  // never takes an item while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // last result frees the input
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data[0] |=> in_ready)
    else $error("input not freed after last");

  // a non-last result is never query, suppressed, add-done or overflow
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data[0] |-> out_data[43:41] <= 3'd3)
    else $error("bad non-final kind");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind range_match_flow_table rmft_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for range_match_flow_table: a directed table of lookups
// and rule adds, then random traffic in several own-range settings, each result
// checked field by field against its typed row or the in-bench flow table model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_W = 11;

  logic clk;
  logic rst_n;

  rmft_stream_if #(.W($bits(rmft_pkg::item_t)))   in_ch();
  rmft_stream_if #(.W($bits(rmft_pkg::result_t))) out_ch();
  rmft_stream_if #(.W(CFG_W))                     cfg_ch();

  range_match_flow_table i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // flow table model state
  rmft_pkg::rule_t tbl [rmft_pkg::RULE_DEPTH];
  logic [15:0]     tbl_hits [rmft_pkg::RULE_DEPTH];
  int              n_rules;
  logic [19:0]     pending_q[$];
  logic [19:0]     asked_q[$];
  logic [9:0]      own_lo, own_hi;

  rmft_pkg::result_t due_results[$];
  int                errors;
  bit                typed_row;
  rmft_pkg::result_t typed_res;
  bit                quiet;
  bit                hold_req;
  logic [19:0]       missed_pairs[$];

  function automatic rmft_pkg::rule_t rule_at(int i);
    rmft_pkg::rule_t r;
    if (i == 0) begin
      r.sl = 10'd0; r.sh = rmft_pkg::MAX_IP; r.dl = own_lo; r.dh = own_hi;
      r.kind = rmft_pkg::RK_FORWARD; r.port = 1'b0;
      return r;
    end
    return tbl[i];
  endfunction

  function automatic int search_rules(logic [9:0] s, logic [9:0] d);
    rmft_pkg::rule_t r;
    for (int i = n_rules - 1; i >= 0; i--) begin
      r = rule_at(i);
      if (s >= r.sl && s <= r.sh && d >= r.dl && d <= r.dh) return i;
    end
    return -1;
  endfunction

  function automatic logic [2:0] verdict(int i);
    rmft_pkg::rule_t r;
    r = rule_at(i);
    if (r.kind == rmft_pkg::RK_FORWARD) return rmft_pkg::K_FWD;
    if (r.kind == rmft_pkg::RK_SEND) return r.port ? rmft_pkg::K_RIGHT : rmft_pkg::K_LEFT;
    return rmft_pkg::K_DROP;
  endfunction

  function automatic void queue_result(logic [2:0] k, logic [9:0] s, logic [9:0] d,
                                       int idx, logic [15:0] h, logic lst);
    rmft_pkg::result_t r;
    r.kind = k; r.src = s; r.dst = d; r.idx = idx[3:0]; r.hits = h; r.last = lst;
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic void hit_rule(int i, logic [9:0] s, logic [9:0] d, logic lst);
    if (tbl_hits[i] != 16'hFFFF) tbl_hits[i] = tbl_hits[i] + 16'd1;
    queue_result(verdict(i), s, d, i, tbl_hits[i], lst);
  endfunction

  // works out the results of one accepted item and updates the table model
  function automatic void classify_item(rmft_pkg::item_t it);
    logic [19:0] pair, kept[$];
    int r;
    bit dup, ovf, seen;
    rmft_pkg::rule_t e;
    if (it.action == 1'b0) begin
      pair = {it.src_ip, it.dst_ip};
      r = search_rules(it.src_ip, it.dst_ip);
      if (r >= 0) begin
        hit_rule(r, it.src_ip, it.dst_ip, 1'b1);
        return;
      end
      seen = 0;
      foreach (asked_q[i]) if (asked_q[i] == pair) seen = 1;
      if (seen) queue_result(rmft_pkg::K_SUPPR, it.src_ip, it.dst_ip, 0, 16'd0, 1'b1);
      else if (asked_q.size() >= rmft_pkg::QUERY_DEPTH ||
               pending_q.size() >= rmft_pkg::PENDING_DEPTH)
        queue_result(rmft_pkg::K_OVF, it.src_ip, it.dst_ip, 0, 16'd0, 1'b1);
      else begin
        asked_q.insert(asked_q.size(), pair);
        pending_q.insert(pending_q.size(), pair);
        queue_result(rmft_pkg::K_QUERY, it.src_ip, it.dst_ip, 0, 16'd0, 1'b1);
      end
    end else begin
      dup = 0; ovf = 0;
      for (int i = 0; i < n_rules; i++) begin
        e = rule_at(i);
        if (e.sl == it.rule.sl && e.sh == it.rule.sh && e.dl == it.rule.dl &&
            e.dh == it.rule.dh && e.kind == it.rule.kind) dup = 1;
      end
      if (!dup) begin
        if (n_rules < rmft_pkg::RULE_DEPTH) begin
          tbl[n_rules] = it.rule;
          tbl_hits[n_rules] = 16'd0;
          n_rules++;
        end else ovf = 1;
      end
      foreach (pending_q[i]) begin
        r = search_rules(pending_q[i][19:10], pending_q[i][9:0]);
        if (r >= 0) hit_rule(r, pending_q[i][19:10], pending_q[i][9:0], 1'b0);
        else kept.insert(kept.size(), pending_q[i]);
      end
      pending_q = kept;
      queue_result(ovf ? rmft_pkg::K_OVF : rmft_pkg::K_DONE, 10'd0, 10'd0, 0, 16'd0, 1'b1);
    end
  endfunction

  // input transfer monitor: predict on acceptance
  always @(posedge clk) begin
    int n0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      n0 = due_results.size();
      classify_item(rmft_pkg::item_t'(in_ch.data));
      if (typed_row) begin
        while (due_results.size() > n0) void'(due_results.pop_back());
        due_results.insert(due_results.size(), typed_res);
      end
    end
  end

  // result transfer checker
  always @(posedge clk) begin
    rmft_pkg::result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = rmft_pkg::result_t'(out_ch.data);
      if (due_results.size() == 0) begin
        $error("unexpected result kind=%0d src=%0d dst=%0d", got.kind, got.src, got.dst);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
        end
        if (got.src !== want.src) begin
          $error("out_src_ip: expected %0d, got %0d", want.src, got.src); errors++;
        end
        if (got.dst !== want.dst) begin
          $error("out_dst_ip: expected %0d, got %0d", want.dst, got.dst); errors++;
        end
        if (got.idx !== want.idx) begin
          $error("rule_index: expected %0d, got %0d", want.idx, got.idx); errors++;
        end
        if (got.hits !== want.hits) begin
          $error("hit_count: expected %0d, got %0d", want.hits, got.hits); errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 0;
        out_ch.ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4);
        out_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else out_ch.ready = 1'b1;
    end
  end

  task automatic send_item(rmft_pkg::item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.data = it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (due_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [9:0] val);
    cfg_ch.data = {idx, val};
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == rmft_pkg::CFG_OWN_LOW) own_lo = val;
    else own_hi = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic rmft_pkg::item_t packet(logic [9:0] s, logic [9:0] d);
    rmft_pkg::item_t it;
    it = '0;
    it.action = 1'b0; it.src_ip = s; it.dst_ip = d;
    return it;
  endfunction

  function automatic rmft_pkg::item_t add_rule(logic [9:0] sl, logic [9:0] sh,
                                               logic [9:0] dl, logic [9:0] dh,
                                               logic [1:0] k, logic p);
    rmft_pkg::item_t it;
    it = '0;
    it.action = 1'b1;
    it.src_ip = 10'($urandom_range(0, 1000));
    it.dst_ip = 10'($urandom_range(0, 1000));
    it.rule.sl = sl; it.rule.sh = sh; it.rule.dl = dl; it.rule.dh = dh;
    it.rule.kind = k; it.rule.port = p;
    return it;
  endfunction

  function automatic rmft_pkg::result_t res(logic [2:0] k, logic [9:0] s, logic [9:0] d,
                                            logic [3:0] idx, logic [15:0] h);
    rmft_pkg::result_t r;
    r.kind = k; r.src = s; r.dst = d; r.idx = idx; r.hits = h; r.last = 1'b1;
    return r;
  endfunction

  function automatic rmft_pkg::item_t random_item();
    logic [9:0] a, b, sl, dl;
    logic [19:0] p;
    if ($urandom_range(0, 9) < 7) begin
      if (missed_pairs.size() != 0 && $urandom_range(0, 3) == 0) begin
        p = missed_pairs[$urandom_range(0, missed_pairs.size() - 1)];
        return packet(p[19:10], p[9:0]);
      end
      a = 10'($urandom_range(0, 1000));
      b = 10'($urandom_range(0, 1000));
      if (missed_pairs.size() < 40) missed_pairs.insert(missed_pairs.size(), {a, b});
      return packet(a, b);
    end
    sl = 10'($urandom_range(0, 1000));
    dl = 10'($urandom_range(0, 1000));
    if ($urandom_range(0, 9) == 0)
      return add_rule(sl, 10'($urandom_range(0, 1000)), dl, 10'($urandom_range(0, 1000)),
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    a = (sl + 10'($urandom_range(0, 400)) > 10'd1000) ? 10'd1000
        : sl + 10'($urandom_range(0, 400));
    b = (dl + 10'($urandom_range(0, 400)) > 10'd1000) ? 10'd1000
        : dl + 10'($urandom_range(0, 400));
    return add_rule(sl, a, dl, b, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endfunction

  typedef struct {
    rmft_pkg::item_t   it;
    bit                typed;
    rmft_pkg::result_t want;
  } stim_row_t;

  stim_row_t plan[$];

  function automatic void add_row(rmft_pkg::item_t it, bit typed, rmft_pkg::result_t want);
    stim_row_t row;
    row.it = it; row.typed = typed; row.want = want;
    plan.insert(plan.size(), row);
  endfunction

  initial begin
    logic [9:0] los[4] = '{10'd0, 10'd1000, 10'd0, 10'd1000};
    logic [9:0] his[4] = '{10'd1000, 10'd0, 10'd0, 10'd1000};
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    errors = 0; typed_row = 0; quiet = 0; hold_req = 0;
    n_rules = 1; own_lo = 10'd0; own_hi = rmft_pkg::MAX_IP;
    foreach (tbl_hits[i]) tbl_hits[i] = 16'd0;
    foreach (tbl[i]) tbl[i] = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // built-in rule right after reset, both address extremes
    add_row(packet(10'd0, 10'd0), 1, res(rmft_pkg::K_FWD, 10'd0, 10'd0, 4'd0, 16'd1));
    add_row(packet(rmft_pkg::MAX_IP, rmft_pkg::MAX_IP), 1,
            res(rmft_pkg::K_FWD, rmft_pkg::MAX_IP, rmft_pkg::MAX_IP, 4'd0, 16'd2));
    foreach (plan[i]) begin
      typed_row = plan[i].typed; typed_res = plan[i].want;
      send_item(plan[i].it);
    end
    drain();
    write_reg(rmft_pkg::CFG_OWN_LOW, 10'd100);
    write_reg(rmft_pkg::CFG_OWN_HIGH, 10'd200);
    plan.delete();
    add_row(packet(10'd5, 10'd150), 1, res(rmft_pkg::K_FWD, 10'd5, 10'd150, 4'd0, 16'd3));
    add_row(packet(10'd5, 10'd50), 1, res(rmft_pkg::K_QUERY, 10'd5, 10'd50, 4'd0, 16'd0));
    add_row(packet(10'd5, 10'd50), 1, res(rmft_pkg::K_SUPPR, 10'd5, 10'd50, 4'd0, 16'd0));
    add_row(packet(10'd7, 10'd999), 1,
            res(rmft_pkg::K_QUERY, 10'd7, 10'd999, 4'd0, 16'd0));
    add_row(add_rule(10'd0, 10'd10, 10'd0, 10'd60, rmft_pkg::RK_DROP, 1'b0), 0, '0);
    // same ranges and kind again: duplicate, only the done result
    add_row(add_rule(10'd0, 10'd10, 10'd0, 10'd60, rmft_pkg::RK_DROP, 1'b1), 1,
            res(rmft_pkg::K_DONE, 10'd0, 10'd0, 4'd0, 16'd0));
    add_row(add_rule(10'd0, 10'd10, 10'd0, 10'd60, 2'd3, 1'b0), 0, '0);
    add_row(packet(10'd3, 10'd20), 0, '0);
    add_row(add_rule(10'd0, rmft_pkg::MAX_IP, 10'd900, 10'd999, rmft_pkg::RK_SEND, 1'b0),
            0, '0);
    add_row(add_rule(10'd0, rmft_pkg::MAX_IP, 10'd300, 10'd400, rmft_pkg::RK_SEND, 1'b1),
            0, '0);
    add_row(packet(rmft_pkg::MAX_IP, 10'd350), 0, '0);
    add_row(add_rule(10'd500, 10'd600, 10'd500, 10'd600, rmft_pkg::RK_FORWARD, 1'b1),
            0, '0);
    add_row(packet(10'd550, 10'd550), 0, '0);
    // inverted source range never matches
    add_row(add_rule(10'd600, 10'd500, 10'd0, rmft_pkg::MAX_IP, rmft_pkg::RK_DROP, 1'b0),
            0, '0);
    add_row(packet(10'd550, 10'd700), 0, '0);
    add_row(packet(10'd511, 10'd682), 0, '0);
    add_row(add_rule(rmft_pkg::MAX_IP, rmft_pkg::MAX_IP, rmft_pkg::MAX_IP, rmft_pkg::MAX_IP,
                     rmft_pkg::RK_SEND, 1'b1), 0, '0);
    add_row(packet(rmft_pkg::MAX_IP, rmft_pkg::MAX_IP), 0, '0);
    foreach (plan[i]) begin
      typed_row = plan[i].typed; typed_res = plan[i].want;
      send_item(plan[i].it);
    end
    typed_row = 0;

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(rmft_pkg::CFG_OWN_LOW, los[ph]);
      write_reg(rmft_pkg::CFG_OWN_HIGH, his[ph]);
      if (ph == 3) quiet = 1;
      for (int n = 0; n < 110; n++) begin
        if (ph == 1 && n == 10) hold_req = 1;
        // sender waits for every outstanding result once
        if (ph == 2 && n == 50) while (due_results.size() != 0) @(negedge clk);
        send_item(random_item());
      end
    end

    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/rmft_pkg.sv
src/rmft_if.sv
src/rmft_dp.sv
src/rmft_ctrl.sv
src/range_match_flow_table.sv
src/rmft_checker.sv
dv/tb.sv
